// ===== sv/nsc_pkg.sv =====
// Shared constants, types and character helpers for the NMEA sentence checker.
`timescale 1ns / 1ps
package nsc_pkg;

    localparam int MAX_SENTENCE = 75;
    localparam int LEN_W        = 7;
    localparam int KIND_W       = 3;
    localparam int NUM_KINDS    = 4;
    localparam int PREFIX_LEN   = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GGA   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RMC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GLL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VTG   = 3'd4;

    typedef struct packed {
        logic                 checksum_ok;
        logic [KIND_W-1:0]    sentence_kind;
        logic [7:0]           computed_sum;
        logic [LEN_W-1:0]     sentence_length;
    } result_t;

    // Uppercase hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] ch;
        if (nibble < 4'd10)
        begin
            ch = 8'h30 + {4'd0, nibble};
        end
        else
        begin
            ch = 8'h37 + {4'd0, nibble};
        end
        return ch;
    endfunction

    // Expected character of a known prefix: kind index 0..3, position 0..5
    function automatic logic [7:0] kind_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = CH_DOLLAR;
            3'd1: ch = 8'h47;                       // G
            3'd2: ch = 8'h4E;                       // N
            3'd3:
            begin
                case (kind)
                    2'd1:    ch = 8'h52;            // R
                    2'd3:    ch = 8'h56;            // V
                    default: ch = 8'h47;            // G
                endcase
            end
            3'd4:
            begin
                case (kind)
                    2'd0:    ch = 8'h47;            // G
                    2'd1:    ch = 8'h4D;            // M
                    2'd2:    ch = 8'h4C;            // L
                    default: ch = 8'h54;            // T
                endcase
            end
            3'd5:
            begin
                case (kind)
                    2'd0:    ch = 8'h41;            // A
                    2'd1:    ch = 8'h43;            // C
                    2'd2:    ch = 8'h4C;            // L
                    default: ch = 8'h47;            // G
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/nmea_sentence_checker_core.sv =====
// Top level of the NMEA 0183 sentence checker.
//
// Input channel: in_valid / in_stall carry rx_byte, one received character
// per item. An item is taken at a rising edge with in_valid high and
// in_stall low.
// Output channel: out_valid / out_stall carry one result per ended sentence
// (checksum_ok, sentence_kind, computed_sum, sentence_length).
// A '$' restarts a sentence without a result. A line feed, or any other
// byte once 75 characters are held, ends the sentence and yields a result.
// A byte is registered on entry in the input register and processed from
// there; an ending byte loads its result into the result register, which
// drives out_valid, once the result slot has room.
// Throughput: one byte per cycle while in_stall is low; the sentence state
// update is a single compare/XOR step between the input and result registers.
// Reset (rst_n low, asynchronous) empties the sentence store and both
// registers; no result is pending afterwards.
// When the receiver stalls, the held result stays put; the input register
// keeps taking bytes that do not end a sentence, and the next ending byte
// waits there, raising in_stall, until the result slot frees up.
`timescale 1ns / 1ps
module nmea_sentence_checker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          checksum_ok,
    output logic [nsc_pkg::KIND_W-1:0]    sentence_kind,
    output logic [7:0]                    computed_sum,
    output logic [nsc_pkg::LEN_W-1:0]     sentence_length
);
    import nsc_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       ends;
    logic       room;
    logic       step;
    result_t    result;

    // Byte proceeds unless it ends a sentence and the result slot is busy
    assign step = held_valid && (!ends || room);

    nsc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .consume    (step),
        .in_stall   (in_stall),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    nsc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .data   (held_byte),
        .ends   (ends),
        .result (result)
    );

    nsc_out_stage u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (step && ends),
        .result          (result),
        .out_stall       (out_stall),
        .room            (room),
        .out_valid       (out_valid),
        .checksum_ok     (checksum_ok),
        .sentence_kind   (sentence_kind),
        .computed_sum    (computed_sum),
        .sentence_length (sentence_length)
    );

    // A valid sentence holds at least "$*XX"
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_ok |-> sentence_length >= LEN_W'(4))
        else $error("checksum_ok on a sentence shorter than four characters");

    a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sentence_kind != KIND_OTHER) |-> sentence_length >= LEN_W'(PREFIX_LEN))
        else $error("sentence kind reported for a short prefix");

    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sentence_length <= LEN_W'(MAX_SENTENCE))
        else $error("sentence length above the store size");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> held_valid && ends && out_valid && out_stall)
        else $error("input stalled without a blocked ending byte");

endmodule

// ===== sv/nsc_in_stage.sv =====
// Input register for received bytes; doubles as the skid stage.
`timescale 1ns / 1ps
module nsc_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] rx_byte,
    input  logic       consume,
    output logic       in_stall,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    import nsc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign in_stall   = valid_reg && !consume;
    assign load       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ===== sv/nsc_frame.sv =====
// Sentence framing state, running XOR, checksum digit and prefix tracking.
`timescale 1ns / 1ps
module nsc_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data,
    output logic             ends,
    output nsc_pkg::result_t result
);
    import nsc_pkg::*;

    logic [LEN_W-1:0]     count_reg,  count_next;
    logic                 began_reg,  began_next;
    logic [7:0]           xor_reg,    xor_next;
    logic                 star_reg,   star_next;
    logic                 stop_reg,   stop_next;
    logic [1:0]           digits_reg, digits_next;
    logic [1:0]           match_reg,  match_next;
    logic [NUM_KINDS-1:0] cand_reg,   cand_next;

    logic       is_dollar;
    logic [3:0] nib;

    assign is_dollar = (data == CH_DOLLAR);
    assign ends = !is_dollar &&
                  ((data == CH_LF) || (count_reg >= LEN_W'(MAX_SENTENCE)));
    assign nib  = (digits_reg == 2'd0) ? xor_reg[7:4] : xor_reg[3:0];

    // Result from the state before the ending byte
    always_comb
    begin
        result.checksum_ok     = began_reg && star_reg && (digits_reg == 2'd2) &&
                                 (match_reg == 2'b11);
        result.sentence_kind   = KIND_OTHER;
        if (began_reg && (count_reg >= LEN_W'(PREFIX_LEN)))
        begin
            if (cand_reg[0])
                result.sentence_kind = KIND_GGA;
            else if (cand_reg[1])
                result.sentence_kind = KIND_RMC;
            else if (cand_reg[2])
                result.sentence_kind = KIND_GLL;
            else if (cand_reg[3])
                result.sentence_kind = KIND_VTG;
        end
        result.computed_sum    = began_reg ? xor_reg : 8'h00;
        result.sentence_length = count_reg;
    end

    always_comb
    begin
        count_next  = count_reg;
        began_next  = began_reg;
        xor_next    = xor_reg;
        star_next   = star_reg;
        stop_next   = stop_reg;
        digits_next = digits_reg;
        match_next  = match_reg;
        cand_next   = cand_reg;
        if (is_dollar)
        begin
            // restart: '$' becomes the first stored character
            count_next  = LEN_W'(1);
            began_next  = 1'b1;
            xor_next    = 8'h00;
            star_next   = 1'b0;
            stop_next   = 1'b0;
            digits_next = 2'd0;
            match_next  = 2'b00;
            cand_next   = '1;
        end
        else if (ends)
        begin
            count_next  = '0;
            began_next  = 1'b0;
            xor_next    = 8'h00;
            star_next   = 1'b0;
            stop_next   = 1'b0;
            digits_next = 2'd0;
            match_next  = 2'b00;
            cand_next   = '1;
        end
        else
        begin
            if (count_reg < LEN_W'(PREFIX_LEN))
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    if (kind_char(2'(k), count_reg[2:0]) != data)
                        cand_next[k] = 1'b0;
                end
            end
            if (count_reg == '0)
            begin
                began_next = 1'b0;
            end
            else if (star_reg)
            begin
                if (digits_reg < 2'd2)
                begin
                    if (data == hex_char(nib))
                        match_next[digits_reg[0]] = 1'b1;
                    digits_next = digits_reg + 2'd1;
                end
            end
            else if (!stop_reg)
            begin
                if (data == CH_NUL)
                    stop_next = 1'b1;
                else if (data == CH_STAR)
                    star_next = 1'b1;
                else
                    xor_next = xor_reg ^ data;
            end
            count_next = count_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            began_reg  <= 1'b0;
            xor_reg    <= 8'h00;
            star_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            digits_reg <= 2'd0;
            match_reg  <= 2'b00;
            cand_reg   <= '1;
        end
        else if (step)
        begin
            count_reg  <= count_next;
            began_reg  <= began_next;
            xor_reg    <= xor_next;
            star_reg   <= star_next;
            stop_reg   <= stop_next;
            digits_reg <= digits_next;
            match_reg  <= match_next;
            cand_reg   <= cand_next;
        end
    end

endmodule

// ===== sv/nsc_out_stage.sv =====
// Result register with valid/stall handshake.
`timescale 1ns / 1ps
module nsc_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  nsc_pkg::result_t              result,
    input  logic                          out_stall,
    output logic                          room,
    output logic                          out_valid,
    output logic                          checksum_ok,
    output logic [nsc_pkg::KIND_W-1:0]    sentence_kind,
    output logic [7:0]                    computed_sum,
    output logic [nsc_pkg::LEN_W-1:0]     sentence_length
);
    import nsc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // free now, or the waiting result leaves this edge
    assign room = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid       = valid_reg;
    assign checksum_ok     = res_reg.checksum_ok;
    assign sentence_kind   = res_reg.sentence_kind;
    assign computed_sum    = res_reg.computed_sum;
    assign sentence_length = res_reg.sentence_length;

endmodule
